### rtl/core/tfss_pkg.sv
// Shared types and constants for the textured floor span shader.
package tfss_pkg;

    // Texture store geometry (fixed, sample addresses wrap to its size)
    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = 12;
    localparam int TEXEL_W     = 32;

    // Coordinate and lighting widths
    localparam int COORD_W = 32;
    localparam int LIGHT_W = 8;
    localparam int CHAN_W  = 8;

    // Configuration port
    localparam int CFG_W       = 3;
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_W-1:0] CFG_LOG2_RESET = 3'd6;
    // Clamped size exponent width (holds up to 15)
    localparam int LOG2_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH_LOG2  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT_LOG2 = 1'b1;

    // Request kinds carried on tuser
    localparam int ACTION_W = 2;
    typedef enum logic [ACTION_W-1:0] {
        ACT_TEXEL = 2'd0,
        ACT_ROW   = 2'd1,
        ACT_PIXEL = 2'd2
    } t_action;

    // Input tdata layout, lowest bit first
    localparam int TD_ADDR_LSB   = 0;
    localparam int TD_TEXEL_LSB  = TD_ADDR_LSB + STORE_AW;
    localparam int TD_U_LSB      = TD_TEXEL_LSB + TEXEL_W;
    localparam int TD_V_LSB      = TD_U_LSB + COORD_W;
    localparam int TD_DU_LSB     = TD_V_LSB + COORD_W;
    localparam int TD_DV_LSB     = TD_DU_LSB + COORD_W;
    localparam int TD_LIGHT_LSB  = TD_DV_LSB + COORD_W;
    localparam int TD_USED       = TD_LIGHT_LSB + LIGHT_W;
    localparam int S_TDATA_W     = ((TD_USED + 7) / 8) * 8;

    // Strobes from the front end to the coordinate unit
    typedef struct packed {
        logic row_load;
        logic pixel_step;
    } t_coord_ctrl;

endpackage

### rtl/core/tfss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tfss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/tfss_coord.sv
// Span coordinate registers, size config and texel address generation.
module tfss_coord #(
    parameter int TEX_LOG2_MAX = 6,
    parameter int FRAC_BITS    = 13
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tfss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tfss_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  tfss_pkg::t_coord_ctrl             i_ctrl,
    input  logic [tfss_pkg::COORD_W-1:0]      i_start_u,
    input  logic [tfss_pkg::COORD_W-1:0]      i_start_v,
    input  logic [tfss_pkg::COORD_W-1:0]      i_step_u,
    input  logic [tfss_pkg::COORD_W-1:0]      i_step_v,
    input  logic [tfss_pkg::LIGHT_W-1:0]      i_light,
    output logic [tfss_pkg::STORE_AW-1:0]     o_addr,
    output logic [tfss_pkg::LIGHT_W-1:0]      o_light
);
    import tfss_pkg::*;

    logic [CFG_W-1:0]   r_wlog2, r_hlog2;
    logic [COORD_W-1:0] r_u, r_v, r_du, r_dv;
    logic [LIGHT_W-1:0] r_light;

    logic [LOG2_W-1:0]   wl, hl;
    logic [STORE_AW-1:0] wmask, hmask, tx, ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlog2 <= CFG_LOG2_RESET;
            r_hlog2 <= CFG_LOG2_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEX_WIDTH_LOG2:  r_wlog2 <= i_cfg_wdata;
                CFG_TEX_HEIGHT_LOG2: r_hlog2 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u     <= '0;
            r_v     <= '0;
            r_du    <= '0;
            r_dv    <= '0;
            r_light <= '0;
        end else if (i_ctrl.row_load) begin
            r_u     <= i_start_u;
            r_v     <= i_start_v;
            r_du    <= i_step_u;
            r_dv    <= i_step_v;
            r_light <= i_light;
        end else if (i_ctrl.pixel_step) begin
            r_u <= r_u + r_du;
            r_v <= r_v + r_dv;
        end
    end

    // Size exponents saturate at the largest supported texture
    always_comb begin
        wl = (LOG2_W'(r_wlog2) > LOG2_W'(TEX_LOG2_MAX)) ? LOG2_W'(TEX_LOG2_MAX)
                                                         : LOG2_W'(r_wlog2);
        hl = (LOG2_W'(r_hlog2) > LOG2_W'(TEX_LOG2_MAX)) ? LOG2_W'(TEX_LOG2_MAX)
                                                         : LOG2_W'(r_hlog2);
        wmask = (STORE_AW'(1) << wl) - STORE_AW'(1);
        hmask = (STORE_AW'(1) << hl) - STORE_AW'(1);
        // Only the low address bits survive the store wrap, so work in 12 bits
        tx = r_u[FRAC_BITS +: STORE_AW] & wmask;
        ty = r_v[FRAC_BITS +: STORE_AW] & hmask;
    end

    assign o_addr  = tx + (ty << wl);
    assign o_light = r_light;

endmodule

### rtl/core/tfss_shade.sv
// Per-channel lightness multiply of an ARGB texel, alpha passed through.
module tfss_shade (
    input  logic [tfss_pkg::TEXEL_W-1:0] i_color,
    input  logic [tfss_pkg::LIGHT_W-1:0] i_light,
    output logic [tfss_pkg::TEXEL_W-1:0] o_color
);
    import tfss_pkg::*;

    logic [CHAN_W+LIGHT_W-1:0] prod_r, prod_g, prod_b;

    always_comb begin
        prod_r = i_color[23:16] * i_light;
        prod_g = i_color[15:8]  * i_light;
        prod_b = i_color[7:0]   * i_light;
        o_color = {i_color[31:24],
                   prod_r[CHAN_W+LIGHT_W-1:LIGHT_W],
                   prod_g[CHAN_W+LIGHT_W-1:LIGHT_W],
                   prod_b[CHAN_W+LIGHT_W-1:LIGHT_W]};
    end

endmodule

### rtl/core/textured_floor_span_shader.sv
// Top level of the textured floor span shader: request decode, pipeline, output register.
// Pixel path: RAM read register (stage 1), then output register, to o_m_tvalid/o_m_tdata.
// Throughput: one request per cycle while i_m_tready is high, through the two-entry pipe;
// texel writes and row starts take effect at their accept edge, no output.
// Reset (i_rst_n low, synchronous): pipe empties, u/v/steps/light clear to zero,
// both size exponents return to 6; texture RAM contents are kept and undefined.
module textured_floor_span_shader #(
    parameter int TEX_LOG2_MAX = 6,
    parameter int FRAC_BITS    = 13
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [tfss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tfss_pkg::CFG_W-1:0]        i_cfg_wdata,
    // Request stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: texel_addr[11:0], texel_data[43:12], start_u[75:44], start_v[107:76],
    //        step_u[139:108], step_v[171:140], light[179:172], zero pad[183:180]
    input  logic [tfss_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // tuser: action[1:0]
    input  logic [tfss_pkg::ACTION_W-1:0]     i_s_tuser,
    // Pixel stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: pixel_color[31:0]
    output logic [tfss_pkg::TEXEL_W-1:0]      o_m_tdata
);
    import tfss_pkg::*;

    logic        s_accept;
    t_action     action;
    logic        texel_wr, pixel_rd;
    t_coord_ctrl coord_ctrl;

    logic [STORE_AW-1:0] rd_addr;
    logic [LIGHT_W-1:0]  row_light;
    logic [TEXEL_W-1:0]  texel_q, shaded;

    // Stage 1 holds the RAM read data plus the light it will be shaded with
    logic               r_s1_valid, n_s1_valid;
    logic [LIGHT_W-1:0] r_s1_light;
    logic               s1_move;

    // Output register
    logic               r_out_valid, n_out_valid;
    logic [TEXEL_W-1:0] r_out_color;

    assign action   = t_action'(i_s_tuser);
    assign s_accept = i_s_tvalid && o_s_tready;

    always_comb begin
        texel_wr = 1'b0;
        pixel_rd = 1'b0;
        coord_ctrl = '0;
        if (s_accept) begin
            case (action)
                ACT_TEXEL: texel_wr = 1'b1;
                ACT_ROW:   coord_ctrl.row_load = 1'b1;
                ACT_PIXEL: begin
                    pixel_rd = 1'b1;
                    coord_ctrl.pixel_step = 1'b1;
                end
                default: ;  // unused code: dropped
            endcase
        end
    end

    // Stage 1 drains into the output register when that is empty or being read
    assign s1_move    = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_move;

    tfss_coord #(
        .TEX_LOG2_MAX (TEX_LOG2_MAX),
        .FRAC_BITS    (FRAC_BITS)
    ) u_coord (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctrl      (coord_ctrl),
        .i_start_u   (i_s_tdata[TD_U_LSB +: COORD_W]),
        .i_start_v   (i_s_tdata[TD_V_LSB +: COORD_W]),
        .i_step_u    (i_s_tdata[TD_DU_LSB +: COORD_W]),
        .i_step_v    (i_s_tdata[TD_DV_LSB +: COORD_W]),
        .i_light     (i_s_tdata[TD_LIGHT_LSB +: LIGHT_W]),
        .o_addr      (rd_addr),
        .o_light     (row_light)
    );

    // Read data only updates on a pixel accept, so a stalled stage 1 keeps its texel
    tfss_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_tex_ram (
        .i_clk   (i_clk),
        .i_we    (texel_wr),
        .i_waddr (i_s_tdata[TD_ADDR_LSB +: STORE_AW]),
        .i_wdata (i_s_tdata[TD_TEXEL_LSB +: TEXEL_W]),
        .i_re    (pixel_rd),
        .i_raddr (rd_addr),
        .o_rdata (texel_q)
    );

    tfss_shade u_shade (
        .i_color (texel_q),
        .i_light (r_s1_light),
        .o_color (shaded)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (pixel_rd) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (s1_move) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pixel_rd) begin
            r_s1_light <= row_light;
        end
        if (s1_move) begin
            r_out_color <= shaded;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_color;

    // A pixel accepted always occupies stage 1 on the next cycle
    a_pixel_enters_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pixel_rd |=> r_s1_valid)
        else $error("pixel request did not reach stage 1");

    // Full pipe under backpressure must refuse requests
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("request accepted while pipe full and stalled");

    // Output only becomes valid from a stage 1 item
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("output valid without stage 1 item");

    // A stalled stage 1 keeps its light
    a_s1_light_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> $stable(r_s1_light))
        else $error("stage 1 light changed while stalled");

endmodule
